@@ rtl/core/vts_pkg.sv @@
// Shared types, keyword tables and helper functions for the verbatim terminator scanner.
`timescale 1ns / 1ps

package vts_pkg;

   localparam int KIND_COUNT          = 12;
   localparam int KIND_W              = 4;
   localparam int CHAR_W              = 8;
   localparam int KW_SLOTS            = 16;
   localparam int KW_LEN_W            = 5;
   localparam int MAX_KEYWORD_LEN_DEF = 16;

   localparam logic [CHAR_W-1:0] CH_COLON      = 8'h3A;
   localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [CHAR_W-1:0] CH_AT         = 8'h40;

   // Kind zero is the short fi form; all others close an environment.
   localparam logic [KIND_W-1:0] KIND_FI = 4'd0;

   localparam logic [KW_LEN_W-1:0] KW_LEN [KIND_COUNT] = '{
      5'd3, 5'd13, 5'd14, 5'd16, 5'd12, 5'd9, 5'd12, 5'd12,
      5'd13, 5'd14, 5'd16, 5'd15
   };

   // Classified character on its way from the front end to the scan engine.
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              at_end;
      logic              cancel_fi;
      logic              mask_ok;
      logic [KIND_W-1:0] kind;
   } item_type;

   // Keyword text, right-justified: the last character sits in the low byte.
   function automatic logic [8*KW_SLOTS-1:0] kw_string(input logic [KIND_W-1:0] kind);
      logic [8*KW_SLOTS-1:0] s;
      s = '0;
      unique case (kind)
         4'd0:    s = "\\fi";
         4'd1:    s = "\\end{comment}";
         4'd2:    s = "\\end{verbatim}";
         4'd3:    s = "\\end{lstlisting}";
         4'd4:    s = "\\end{minted}";
         4'd5:    s = "\\end{asy}";
         4'd6:    s = "\\end{asydef}";
         4'd7:    s = "\\end{pycode}";
         4'd8:    s = "\\end{luacode}";
         4'd9:    s = "\\end{luacode*}";
         4'd10:   s = "\\end{sagesilent}";
         4'd11:   s = "\\end{sageblock}";
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic logic [KW_LEN_W-1:0] kw_len(input logic [KIND_W-1:0] kind);
      logic [KW_LEN_W-1:0] len;
      len = '0;
      if (int'(kind) < KIND_COUNT) begin
         len = KW_LEN[kind];
      end
      return len;
   endfunction

   // Character at position idx of the keyword; idx is always below the length.
   function automatic logic [CHAR_W-1:0] kw_char(input logic [KIND_W-1:0] kind,
                                                  input logic [KW_LEN_W-1:0] idx);
      logic [8*KW_SLOTS-1:0] s;
      logic [KW_LEN_W-1:0]   slot;
      s    = kw_string(kind);
      slot = kw_len(kind) - 5'd1 - idx;
      return s[8*slot[KW_LEN_W-2:0] +: CHAR_W];
   endfunction

endpackage

@@ rtl/core/vts_front.sv @@
// Front end: accepts characters, classifies them and registers the classified transaction.
`timescale 1ns / 1ps

module vts_front
   import vts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [KIND_COUNT-1:0] valid_mask,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [CHAR_W-1:0]     in_ch,
   input  logic                  in_at_end,
   output logic                  out_valid,
   input  logic                  out_ready,
   output item_type              out_item
);

   logic              valid_ff;
   logic              valid_in;
   item_type          item_ff;
   item_type          item_in;
   logic [KIND_W-1:0] kind;
   logic [KIND_W:0]   bit_count;
   logic              is_letter;

   // Mask decode: count of set bits and index of the lowest set bit.
   always_comb begin
      kind      = '0;
      bit_count = '0;
      for (int i = KIND_COUNT - 1; i >= 0; i--) begin
         if (valid_mask[i]) begin
            kind = KIND_W'(i);
         end
      end
      for (int i = 0; i < KIND_COUNT; i++) begin
         bit_count = bit_count + {{KIND_W{1'b0}}, valid_mask[i]};
      end
   end

   always_comb begin
      is_letter = (in_ch >= "a" && in_ch <= "z") || (in_ch >= "A" && in_ch <= "Z");
      item_in.ch        = in_ch;
      item_in.at_end    = in_at_end;
      item_in.cancel_fi = is_letter || in_ch == CH_COLON || in_ch == CH_UNDERSCORE
                          || in_ch == CH_AT;
      item_in.mask_ok   = (bit_count == (KIND_W + 1)'(1));
      item_in.kind      = item_in.mask_ok ? kind : '0;
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ rtl/core/vts_queue.sv @@
// Two-entry queue that decouples the front end from the scan engine.
`timescale 1ns / 1ps

module vts_queue
   import vts_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   item_type   mem [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/vts_back.sv @@
// Scan engine: keyword matcher state and the registered result stage.
`timescale 1ns / 1ps

module vts_back
   import vts_pkg::*;
#(
   parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  item_type          in_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_consumed,
   output logic              rsp_mark_end,
   output logic              rsp_done_res,
   output logic              rsp_found,
   output logic [KIND_W-1:0] rsp_symbol
);

   localparam int POS_W = $clog2(MAX_KEYWORD_LEN + 1);
   localparam logic [KW_LEN_W-1:0] LEN_CAP = KW_LEN_W'(MAX_KEYWORD_LEN);

   logic [POS_W-1:0]    match_pos_ff;
   logic [POS_W-1:0]    match_pos_in;
   logic                suffix_check_ff;
   logic                suffix_check_in;
   logic                marked_ff;
   logic                marked_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                consumed_ff;
   logic                consumed_in;
   logic                mark_end_ff;
   logic                mark_end_in;
   logic                done_ff;
   logic                done_in;
   logic                found_ff;
   logic                found_in;
   logic [KIND_W-1:0]   symbol_ff;
   logic [KIND_W-1:0]   symbol_in;
   logic                load;
   logic [KW_LEN_W-1:0] len;
   logic [KW_LEN_W-1:0] pos;
   logic [KW_LEN_W-1:0] pos_next;

   assign load     = in_valid && (!rsp_valid_ff || rsp_ready);
   assign in_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      len = (kw_len(in_item.kind) > LEN_CAP) ? LEN_CAP : kw_len(in_item.kind);
      // A stale position past the end of the selected keyword restarts at zero.
      pos = (KW_LEN_W'(match_pos_ff) >= len) ? '0 : KW_LEN_W'(match_pos_ff);
      pos_next = pos + 5'd1;

      match_pos_in    = match_pos_ff;
      suffix_check_in = suffix_check_ff;
      marked_in       = marked_ff;
      consumed_in     = 1'b0;
      mark_end_in     = 1'b0;
      done_in         = 1'b0;
      found_in        = 1'b0;
      symbol_in       = in_item.kind;

      if (!in_item.mask_ok) begin
         done_in         = 1'b1;
         match_pos_in    = '0;
         suffix_check_in = 1'b0;
         marked_in       = 1'b0;
      end else if (in_item.at_end) begin
         done_in         = 1'b1;
         found_in        = marked_ff;
         match_pos_in    = '0;
         suffix_check_in = 1'b0;
         marked_in       = 1'b0;
      end else if (suffix_check_ff) begin
         if (in_item.cancel_fi) begin
            consumed_in     = 1'b1;
            mark_end_in     = 1'b1;
            marked_in       = 1'b1;
            suffix_check_in = 1'b0;
            match_pos_in    = '0;
         end else begin
            done_in         = 1'b1;
            found_in        = marked_ff;
            match_pos_in    = '0;
            suffix_check_in = 1'b0;
            marked_in       = 1'b0;
         end
      end else if (in_item.ch == kw_char(in_item.kind, pos)) begin
         consumed_in = 1'b1;
         if (pos_next == len) begin
            match_pos_in = '0;
            if (in_item.kind == KIND_FI) begin
               suffix_check_in = 1'b1;
            end else begin
               done_in         = 1'b1;
               found_in        = marked_ff;
               suffix_check_in = 1'b0;
               marked_in       = 1'b0;
            end
         end else begin
            match_pos_in = POS_W'(pos_next);
         end
      end else if (pos != '0 && in_item.ch == kw_char(in_item.kind, '0)) begin
         // Mismatch after a partial match, but the character restarts the keyword.
         consumed_in  = 1'b1;
         match_pos_in = POS_W'(1);
      end else begin
         consumed_in  = 1'b1;
         mark_end_in  = 1'b1;
         marked_in    = 1'b1;
         match_pos_in = '0;
      end

      rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_pos_ff    <= '0;
         suffix_check_ff <= 1'b0;
         marked_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            match_pos_ff    <= match_pos_in;
            suffix_check_ff <= suffix_check_in;
            marked_ff       <= marked_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         consumed_ff <= consumed_in;
         mark_end_ff <= mark_end_in;
         done_ff     <= done_in;
         found_ff    <= found_in;
         symbol_ff   <= symbol_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_consumed = consumed_ff;
   assign rsp_mark_end = mark_end_ff;
   assign rsp_done_res = done_ff;
   assign rsp_found    = found_ff;
   assign rsp_symbol   = symbol_ff;

endmodule

@@ rtl/core/verbatim_terminator_scanner.sv @@
// Top level of the verbatim terminator scanner.
//
// Usage:
//   The request channel (req_valid/req_ready) carries one text character per
//   transaction in req_ch, or req_at_end when the text has ended. Every
//   request produces exactly one response transaction on rsp_valid/rsp_ready
//   telling whether the character was consumed, whether the token end moved
//   past it, and whether the scan is done (with rsp_found and rsp_symbol).
//   csr_wr_en/csr_wr_data write the one-hot kind mask; write it only while no
//   transaction is in flight. A mask that is not one-hot answers every
//   request with done and nothing found.
//   A request passes the front register, then a queue entry, then the result
//   register before its response is valid.
//   Throughput: one character per cycle while rsp_ready stays high, limited by
//   the combinational keyword compare and position update in the scan engine.
//   Reset clears the mask, the matcher state and all pipeline valids.
//   When rsp_ready is low the result register holds; the two-entry queue and
//   the front register absorb further requests before req_ready drops.
`timescale 1ns / 1ps

module verbatim_terminator_scanner
   import vts_pkg::*;
#(
   parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [KIND_COUNT-1:0] csr_wr_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHAR_W-1:0]     req_ch,
   input  logic                  req_at_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_consumed,
   output logic                  rsp_mark_end,
   output logic                  rsp_done_res,
   output logic                  rsp_found,
   output logic [KIND_W-1:0]     rsp_symbol
);

   logic [KIND_COUNT-1:0] valid_mask_ff;
   logic                  front_valid;
   logic                  front_ready;
   item_type              front_item;
   logic                  queue_valid;
   logic                  queue_ready;
   item_type              queue_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_mask_ff <= '0;
      end else if (csr_wr_en) begin
         valid_mask_ff <= csr_wr_data;
      end
   end

   vts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .valid_mask (valid_mask_ff),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_ch      (req_ch),
      .in_at_end  (req_at_end),
      .out_valid  (front_valid),
      .out_ready  (front_ready),
      .out_item   (front_item)
   );

   vts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_item   (queue_item)
   );

   vts_back #(
      .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (queue_valid),
      .in_ready     (queue_ready),
      .in_item      (queue_item),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_consumed (rsp_consumed),
      .rsp_mark_end (rsp_mark_end),
      .rsp_done_res (rsp_done_res),
      .rsp_found    (rsp_found),
      .rsp_symbol   (rsp_symbol)
   );

endmodule

@@ test/verbatim_scan_checker.sv @@
// Checker for the verbatim terminator scanner: predicts every response and compares it.
`timescale 1ns / 1ps

module verbatim_scan_checker
   import vts_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [KIND_COUNT-1:0] csr_wr_data,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [CHAR_W-1:0]     req_ch,
   input  logic                  req_at_end,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_consumed,
   input  logic                  rsp_mark_end,
   input  logic                  rsp_done_res,
   input  logic                  rsp_found,
   input  logic [KIND_W-1:0]     rsp_symbol,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct packed {
      logic              consumed;
      logic              mark_end;
      logic              done_res;
      logic              found;
      logic [KIND_W-1:0] symbol;
   } scan_result_type;

   scan_result_type       expected_scan [$];
   logic [KIND_COUNT-1:0] kind_mask;
   logic [KW_LEN_W-1:0]   match_pos;
   logic                  fi_pending;
   logic                  token_marked;

   function automatic string keyword(input int kind);
      case (kind)
         0:       return "\\fi";
         1:       return "\\end{comment}";
         2:       return "\\end{verbatim}";
         3:       return "\\end{lstlisting}";
         4:       return "\\end{minted}";
         5:       return "\\end{asy}";
         6:       return "\\end{asydef}";
         7:       return "\\end{pycode}";
         8:       return "\\end{luacode}";
         9:       return "\\end{luacode*}";
         10:      return "\\end{sagesilent}";
         11:      return "\\end{sageblock}";
         default: return "";
      endcase
   endfunction

   // Letters and a few punctuation marks continue a control word, so \fi is not closed.
   function automatic bit fi_breaker(input logic [CHAR_W-1:0] c);
      return c == ":" || c == "_" || c == "@" ||
             (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic void restart_scan();
      match_pos    = '0;
      fi_pending   = 1'b0;
      token_marked = 1'b0;
   endfunction

   function automatic scan_result_type scan_char(input logic [CHAR_W-1:0] c, input logic eoi);
      scan_result_type r;
      int              kind;
      int              len;
      int              p;
      string           kw;
      r = '0;
      if (kind_mask == '0 || (kind_mask & (kind_mask - 1'b1)) != '0) begin
         r.done_res = 1'b1;
         restart_scan();
      end else begin
         kind = 0;
         while (!kind_mask[kind]) kind++;
         r.symbol = KIND_W'(kind);
         kw       = keyword(kind);
         len      = kw.len();
         if (len > MAX_KEYWORD_LEN_DEF) len = MAX_KEYWORD_LEN_DEF;
         if (eoi) begin
            r.done_res = 1'b1;
            r.found    = token_marked;
            restart_scan();
         end else if (fi_pending) begin
            if (fi_breaker(c)) begin
               r.consumed   = 1'b1;
               r.mark_end   = 1'b1;
               token_marked = 1'b1;
               fi_pending   = 1'b0;
               match_pos    = '0;
            end else begin
               r.done_res = 1'b1;
               r.found    = token_marked;
               restart_scan();
            end
         end else begin
            // A position left over from a longer keyword starts over.
            p = match_pos;
            if (p >= len) p = 0;
            if (c == kw[p]) begin
               r.consumed = 1'b1;
               p++;
               if (p == len) begin
                  if (kind == 0) begin
                     fi_pending = 1'b1;
                     match_pos  = '0;
                  end else begin
                     r.done_res = 1'b1;
                     r.found    = token_marked;
                     restart_scan();
                  end
               end else begin
                  match_pos = KW_LEN_W'(p);
               end
            end else if (p > 0 && c == kw[0]) begin
               r.consumed = 1'b1;
               match_pos  = KW_LEN_W'(1);
            end else begin
               r.consumed   = 1'b1;
               r.mark_end   = 1'b1;
               token_marked = 1'b1;
               match_pos    = '0;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      scan_result_type got;
      scan_result_type want;
      if (reset) begin
         kind_mask = '0;
         restart_scan();
         expected_scan.delete();
         mismatches  = 0;
         outstanding = 0;
      end else begin
         if (csr_wr_en) kind_mask = csr_wr_data;
         if (req_valid && req_ready) expected_scan.push_back(scan_char(req_ch, req_at_end));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_consumed, rsp_mark_end, rsp_done_res, rsp_found, rsp_symbol};
            if (expected_scan.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response transaction with nothing expected", $realtime);
            end else begin
               want = expected_scan.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: expected consumed=%0b mark_end=%0b done=%0b found=%0b symbol=%0d",
                              $realtime, want.consumed, want.mark_end, want.done_res,
                              want.found, want.symbol);
                     $display("%0t: got      consumed=%0b mark_end=%0b done=%0b found=%0b symbol=%0d",
                              $realtime, got.consumed, got.mark_end, got.done_res,
                              got.found, got.symbol);
                  end
               end
            end
         end
         outstanding = expected_scan.size();
      end
   end

endmodule

@@ test/tb_verbatim_terminator_scanner.sv @@
// Stimulus and verdict for the verbatim terminator scanner testbench.
`timescale 1ns / 1ps

module tb_verbatim_terminator_scanner;
   import vts_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [KIND_COUNT-1:0] csr_wr_data;
   logic                  req_valid;
   logic                  req_ready;
   logic [CHAR_W-1:0]     req_ch;
   logic                  req_at_end;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_consumed;
   logic                  rsp_mark_end;
   logic                  rsp_done_res;
   logic                  rsp_found;
   logic [KIND_W-1:0]     rsp_symbol;
   int                    mismatches;
   int                    pending;

   int                    items_sent;
   logic [KIND_COUNT-1:0] cur_mask;
   bit                    calm;

   verbatim_terminator_scanner u_dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_ch       (req_ch),
      .req_at_end   (req_at_end),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_consumed (rsp_consumed),
      .rsp_mark_end (rsp_mark_end),
      .rsp_done_res (rsp_done_res),
      .rsp_found    (rsp_found),
      .rsp_symbol   (rsp_symbol)
   );

   verbatim_scan_checker u_check (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_ch       (req_ch),
      .req_at_end   (req_at_end),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_consumed (rsp_consumed),
      .rsp_mark_end (rsp_mark_end),
      .rsp_done_res (rsp_done_res),
      .rsp_found    (rsp_found),
      .rsp_symbol   (rsp_symbol),
      .mismatches   (mismatches),
      .outstanding  (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Response side: random stalls, mostly short, now and then long.
   initial begin : rsp_side
      int hold;
      int r;
      bit level;
      hold      = 0;
      level     = 1'b1;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            r = $urandom_range(0, 99);
            if (r < 65) begin
               level = 1'b1;
               hold  = $urandom_range(1, 10);
            end else if (r < 93) begin
               level = 1'b0;
               hold  = $urandom_range(1, 3);
            end else begin
               level = 1'b0;
               hold  = $urandom_range(8, 40);
            end
         end
         hold--;
         rsp_ready <= level || calm;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Presents one character (or end of text) and returns once the transaction is taken.
   task automatic send(input logic [CHAR_W-1:0] c, input logic eoi);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch     <= c;
      req_at_end <= eoi;
      req_valid  <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send(text[i], 1'b0);
   endtask

   // Holds off the sender until every expected response has arrived.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_mask(input logic [KIND_COUNT-1:0] m);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      cur_mask    = m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CHAR_W-1:0] noise_char(input string kw);
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return CHAR_W'($urandom_range(32, 126));
      if (r < 70) return kw[$urandom_range(0, kw.len() - 1)];
      if (r < 80) return "\\";
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   // One scan: some text, then usually the terminator, sometimes broken off or cut by end of text.
   task automatic random_scan();
      int    kind;
      int    r;
      string kw;
      string breakers;
      string closers;
      breakers = ":_@aZiq";
      closers  = " 0}{\\.";
      kind     = $urandom_range(0, KIND_COUNT - 1);
      for (int k = 0; k < KIND_COUNT; k++) begin
         if (cur_mask == (KIND_COUNT'(1) << k) && $urandom_range(0, 99) < 80) kind = k;
      end
      kw = u_check.keyword(kind);
      if ($urandom_range(0, 99) < 5) begin
         send(CHAR_W'($urandom), 1'b1);
         return;
      end
      repeat ($urandom_range(0, 6)) send(noise_char(kw), 1'b0);
      r = $urandom_range(0, 99);
      if (r < 15) begin
         send_text(kw.substr(0, $urandom_range(0, kw.len() - 2)));
         repeat ($urandom_range(1, 3)) send(noise_char(kw), 1'b0);
      end
      send_text(kw);
      r = $urandom_range(0, 99);
      if (kind == 0) begin
         if (r < 45) send(breakers[$urandom_range(0, breakers.len() - 1)], 1'b0);
         else if (r < 55) send(CHAR_W'($urandom_range(65, 90)), 1'b0);
         else if (r < 90) send(closers[$urandom_range(0, closers.len() - 1)], 1'b0);
         else send(CHAR_W'($urandom), 1'b1);
      end else if (r < 15) begin
         send(CHAR_W'($urandom), 1'b1);
      end
   endtask

   initial begin : stimulus
      int r;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_ch      = '0;
      req_at_end  = 1'b0;
      items_sent  = 0;
      cur_mask    = '0;
      calm        = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, no idling. With the reset mask every transaction ends the scan.
      send("A", 1'b0);
      send(8'h00, 1'b1);
      load_mask(12'h001);
      send(8'hFF, 1'b0);
      send_text("\\fi:");
      send_text("\\fi");
      send(8'h00, 1'b1);
      send_text("\\fi");
      send(8'h00, 1'b0);
      // Switch kinds mid-scan with a partial match no shorter than the new keyword.
      load_mask(12'h800);
      send_text("\\end{sage");
      load_mask(12'h020);
      send("}", 1'b0);
      send(8'h00, 1'b1);

      while (items_sent < 1420) begin
         r = $urandom_range(0, 99);
         if (r < 75) load_mask(KIND_COUNT'(1) << $urandom_range(0, KIND_COUNT - 1));
         else if (r < 83) load_mask('0);
         else if (r < 91) load_mask('1);
         else load_mask(KIND_COUNT'($urandom_range(0, 4095)));
         calm = ($urandom_range(0, 9) == 0);
         repeat ($urandom_range(3, 10)) random_scan();
      end
      calm = 1'b0;

      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/vts_pkg.sv
rtl/core/vts_front.sv
rtl/core/vts_queue.sv
rtl/core/vts_back.sv
rtl/core/verbatim_terminator_scanner.sv
test/verbatim_scan_checker.sv
test/tb_verbatim_terminator_scanner.sv
